// ----- sv/dstu_pkg.sv -----
// Shared types, codes and constants for the delayed start seconds timer.
package dstu_pkg;

	localparam int TICKS_PER_SECOND_DEF = 128;

	localparam int CMD_W   = 2;
	localparam int LIMIT_W = 7;
	localparam int DELAY_W = 15;
	localparam int FINE_W  = 16;
	localparam int EVENT_W = 2;
	localparam int SECS_W  = 7;
	localparam int SUB_W   = 15;

	// Tick count sits this many bits up inside sub_ticks; fine count drops this many bits.
	localparam int TICK_SHIFT = 8;
	localparam int FINE_SHIFT = 4;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
	localparam logic [EVENT_W-1:0] EV_STARTED  = 2'd1;
	localparam logic [EVENT_W-1:0] EV_SECOND   = 2'd2;
	localparam logic [EVENT_W-1:0] EV_COMPLETE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [LIMIT_W-1:0] seconds_limit;
		logic [DELAY_W-1:0] delay_ticks;
		logic [FINE_W-1:0]  fine_count;
	} item_t;

	typedef struct packed {
		logic [EVENT_W-1:0] event_code;
		logic               read_valid;
		logic [SECS_W-1:0]  elapsed_seconds;
		logic [SUB_W-1:0]   sub_ticks;
	} result_t;

endpackage

// ----- sv/dstu_core.sv -----
// Timer state registers and the combinational next-state and result logic.
module dstu_core #(
	parameter int TICKS_PER_SECOND = dstu_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  dstu_pkg::item_t  item,
	output dstu_pkg::result_t result
);

	localparam int TW = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
	localparam logic [TW:0] TPS_C = (TW+1)'(TICKS_PER_SECOND);

	logic [TW-1:0]                tick_q, tick_d;
	logic [dstu_pkg::SECS_W-1:0]  secs_q, secs_d;
	logic [dstu_pkg::DELAY_W-1:0] delay_q, delay_d;
	logic [dstu_pkg::LIMIT_W-1:0] limit_q, limit_d;
	logic clear_q, clear_d;
	logic stop_q, stop_d;
	logic delaying_q, delaying_d;
	logic running_q, running_d;

	logic [TW:0]   tick_inc;
	logic [31:0]   sub_w;

	always_comb begin
		tick_d     = tick_q;
		secs_d     = secs_q;
		delay_d    = delay_q;
		limit_d    = limit_q;
		clear_d    = clear_q;
		stop_d     = stop_q;
		delaying_d = delaying_q;
		running_d  = running_q;
		result     = '0;
		tick_inc   = '0;
		sub_w      = (32'(tick_q) << dstu_pkg::TICK_SHIFT) |
		             32'(item.fine_count >> dstu_pkg::FINE_SHIFT);

		unique case (item.command)
			dstu_pkg::CMD_START: begin
				stop_d     = 1'b0;
				running_d  = 1'b0;
				limit_d    = item.seconds_limit;
				delay_d    = (item.delay_ticks == '0) ? dstu_pkg::DELAY_W'(1) : item.delay_ticks;
				clear_d    = 1'b1;
				delaying_d = 1'b1;
			end
			dstu_pkg::CMD_STOP: begin
				stop_d = 1'b1;
			end
			dstu_pkg::CMD_READ: begin
				if (running_q) begin
					result.read_valid      = 1'b1;
					result.elapsed_seconds = secs_q;
					result.sub_ticks       = sub_w[dstu_pkg::SUB_W-1:0];
				end
			end
			default: begin
				if (clear_d) begin
					tick_d  = '0;
					secs_d  = '0;
					clear_d = 1'b0;
				end
				if (stop_d) begin
					tick_d     = '0;
					secs_d     = '0;
					delaying_d = 1'b0;
					running_d  = 1'b0;
					stop_d     = 1'b0;
				end
				if (delaying_d) begin
					delay_d = delay_d - dstu_pkg::DELAY_W'(1);
					if (delay_d == '0) begin
						delaying_d        = 1'b0;
						running_d         = 1'b1;
						result.event_code = dstu_pkg::EV_STARTED;
					end
				end
				if (running_d) begin
					tick_inc = {1'b0, tick_d} + (TW+1)'(1);
					tick_d   = tick_inc[TW-1:0];
					if (tick_inc >= TPS_C) begin
						tick_d = '0;
						secs_d = secs_d + dstu_pkg::SECS_W'(1);
						if (result.event_code == dstu_pkg::EV_NONE) begin
							result.elapsed_seconds = secs_d;
							result.event_code      = (secs_d == limit_d) ?
								dstu_pkg::EV_COMPLETE : dstu_pkg::EV_SECOND;
						end
						if (secs_d == limit_d)
							stop_d = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			secs_q     <= '0;
			delay_q    <= '0;
			limit_q    <= '0;
			clear_q    <= 1'b0;
			stop_q     <= 1'b0;
			delaying_q <= 1'b0;
			running_q  <= 1'b0;
		end else if (fire) begin
			tick_q     <= tick_d;
			secs_q     <= secs_d;
			delay_q    <= delay_d;
			limit_q    <= limit_d;
			clear_q    <= clear_d;
			stop_q     <= stop_d;
			delaying_q <= delaying_d;
			running_q  <= running_d;
		end
	end

endmodule

// ----- sv/delayed_start_seconds_timer_unit.sv -----
// Top level of the delayed start seconds timer: input register, core logic, result register.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------------------
//  input   | in_valid / in_stall   | command, seconds_limit, delay_ticks, fine_count
//  output  | out_valid / out_stall | event_code, read_valid, elapsed_seconds, sub_ticks
//
// Every input transfer yields exactly one output transfer. An item lands in the input
// register at its transfer, is processed by the core while it sits there, the timer
// state updating as the item moves on, and its result is held in the output register;
// one item is taken every cycle while the result register is not held by a stall.
// The asynchronous reset clears the timer state and both valid flags.
// A stall on the output holds the result register; the input register then keeps its item
// and in_stall rises, but while the result register is free or being drained the input
// is never stalled.
module delayed_start_seconds_timer_unit #(
	parameter int TICKS_PER_SECOND = dstu_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dstu_pkg::CMD_W-1:0]     command,
	input  logic [dstu_pkg::LIMIT_W-1:0]   seconds_limit,
	input  logic [dstu_pkg::DELAY_W-1:0]   delay_ticks,
	input  logic [dstu_pkg::FINE_W-1:0]    fine_count,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dstu_pkg::EVENT_W-1:0]   event_code,
	output logic                           read_valid,
	output logic [dstu_pkg::SECS_W-1:0]    elapsed_seconds,
	output logic [dstu_pkg::SUB_W-1:0]     sub_ticks
);

	// Input stage.
	logic              valid_s1;
	dstu_pkg::item_t   item_s1;

	// Result stage.
	logic              out_valid_q;
	dstu_pkg::result_t res_q;
	dstu_pkg::result_t res_d;

	logic advance;
	logic in_xfer;

	// The item in the input register moves on when the result register is empty or is
	// handing its result over in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.command       <= command;
			item_s1.seconds_limit <= seconds_limit;
			item_s1.delay_ticks   <= delay_ticks;
			item_s1.fine_count    <= fine_count;
		end
	end

	// Timer state and the per-item update; the state commits only when the item advances.
	dstu_core #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_code      = res_q.event_code;
	assign read_valid      = res_q.read_valid;
	assign elapsed_seconds = res_q.elapsed_seconds;
	assign sub_ticks       = res_q.sub_ticks;

endmodule

// ----- tb/sv/timer_report_monitor.sv -----
// Transfer monitor that predicts and checks every report of the delayed start seconds timer.
`timescale 1ns / 100ps

module timer_report_monitor
	import dstu_pkg::*;
#(
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [CMD_W-1:0]   command,
	input  logic [LIMIT_W-1:0] seconds_limit,
	input  logic [DELAY_W-1:0] delay_ticks,
	input  logic [FINE_W-1:0]  fine_count,

	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [EVENT_W-1:0] event_code,
	input  logic               read_valid,
	input  logic [SECS_W-1:0]  elapsed_seconds,
	input  logic [SUB_W-1:0]   sub_ticks,

	output int                 mismatches,
	output int                 outstanding
);

	// Wide enough for the count to reach the rollover value, TICKS_PER_SECOND.
	localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);

	logic [TICK_W-1:0]  tick_cnt;
	logic [SECS_W-1:0]  sec_cnt;
	logic [DELAY_W-1:0] delay_left;
	logic [LIMIT_W-1:0] limit_held;
	logic               clear_pend;
	logic               stop_pend;
	logic               delaying;
	logic               running;

	result_t timer_reports_q[$];
	result_t want;
	item_t   taken_item;
	int      taken;
	int      delivered;

	assign outstanding = taken - delivered;

	// Applies one command to the predicted timer state and returns the report it causes.
	function automatic result_t advance_timer(input item_t it);
		result_t     r;
		logic [31:0] wide;
		r = '0;
		case (it.command)
			CMD_START: begin
				stop_pend  = 1'b0;
				running    = 1'b0;
				limit_held = it.seconds_limit;
				delay_left = (it.delay_ticks == '0) ? DELAY_W'(1) : it.delay_ticks;
				clear_pend = 1'b1;
				delaying   = 1'b1;
			end
			CMD_STOP: begin
				stop_pend = 1'b1;
			end
			CMD_READ: begin
				if (running) begin
					r.read_valid      = 1'b1;
					r.elapsed_seconds = sec_cnt;
					wide = (32'(tick_cnt) << TICK_SHIFT) | (32'(it.fine_count) >> FINE_SHIFT);
					r.sub_ticks       = wide[SUB_W-1:0];
				end
			end
			CMD_TICK: begin
				if (clear_pend) begin
					tick_cnt   = '0;
					sec_cnt    = '0;
					clear_pend = 1'b0;
				end
				if (stop_pend) begin
					tick_cnt  = '0;
					sec_cnt   = '0;
					delaying  = 1'b0;
					running   = 1'b0;
					stop_pend = 1'b0;
				end
				if (delaying) begin
					delay_left = delay_left - DELAY_W'(1);
					if (delay_left == '0) begin
						delaying     = 1'b0;
						running      = 1'b1;
						r.event_code = EV_STARTED;
					end
				end
				if (running) begin
					tick_cnt = tick_cnt + TICK_W'(1);
					if (int'(tick_cnt) >= TICKS_PER_SECOND) begin
						tick_cnt = '0;
						sec_cnt  = sec_cnt + SECS_W'(1);
						if (r.event_code == EV_NONE) begin
							r.elapsed_seconds = sec_cnt;
							r.event_code = (sec_cnt == limit_held) ? EV_COMPLETE : EV_SECOND;
						end
						if (sec_cnt == limit_held)
							stop_pend = 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt   <= '0;
			sec_cnt    <= '0;
			delay_left <= '0;
			limit_held <= '0;
			clear_pend <= 1'b0;
			stop_pend  <= 1'b0;
			delaying   <= 1'b0;
			running    <= 1'b0;
			timer_reports_q.delete();
			taken      <= 0;
			delivered  <= 0;
			mismatches <= 0;
		end else begin
			// The output side goes first so a report is never matched to a same-edge command.
			if (out_valid && !out_stall) begin
				if (timer_reports_q.size() == 0) begin
					$display("%0t: report with no command waiting: event %0d read %0d secs %0d sub %0d",
						$time, event_code, read_valid, elapsed_seconds, sub_ticks);
					mismatches++;
				end else begin
					want = timer_reports_q.pop_front();
					check_field("event_code", want.event_code, event_code);
					check_field("read_valid", want.read_valid, read_valid);
					check_field("elapsed_seconds", want.elapsed_seconds, elapsed_seconds);
					check_field("sub_ticks", want.sub_ticks, sub_ticks);
					delivered++;
				end
			end
			if (in_valid && !in_stall) begin
				taken_item = '{command, seconds_limit, delay_ticks, fine_count};
				timer_reports_q.push_back(advance_timer(taken_item));
				taken++;
			end
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top of the delayed start seconds timer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import dstu_pkg::*;

	localparam int TPS = TICKS_PER_SECOND_DEF;

	// Total number of items to offer, directed part included.
	localparam int TOTAL_ITEMS = 1300;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_stall;
	logic [CMD_W-1:0]   command       = CMD_TICK;
	logic [LIMIT_W-1:0] seconds_limit = '0;
	logic [DELAY_W-1:0] delay_ticks   = '0;
	logic [FINE_W-1:0]  fine_count    = '0;
	logic               out_valid;
	logic               out_stall     = 1'b0;
	logic [EVENT_W-1:0] event_code;
	logic               read_valid;
	logic [SECS_W-1:0]  elapsed_seconds;
	logic [SUB_W-1:0]   sub_ticks;

	int mismatches;
	int outstanding;
	int sent = 0;

	always #5 clk = ~clk;

	delayed_start_seconds_timer_unit #(
		.TICKS_PER_SECOND(TPS)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.seconds_limit   (seconds_limit),
		.delay_ticks     (delay_ticks),
		.fine_count      (fine_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_code      (event_code),
		.read_valid      (read_valid),
		.elapsed_seconds (elapsed_seconds),
		.sub_ticks       (sub_ticks)
	);

	// The monitor sits beside the block and sees both channels exactly as the block does.
	timer_report_monitor #(
		.TICKS_PER_SECOND(TPS)
	) report_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.seconds_limit   (seconds_limit),
		.delay_ticks     (delay_ticks),
		.fine_count      (fine_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_code      (event_code),
		.read_valid      (read_valid),
		.elapsed_seconds (elapsed_seconds),
		.sub_ticks       (sub_ticks),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	// Offers one command and returns at the edge where its transfer happens. Before the
	// offer the sender may sit idle for a few cycles, except in a quiet stretch of items
	// where it offers back to back. The payload only changes once the transfer is done.
	task automatic offer(input logic [CMD_W-1:0] cmd, input logic [LIMIT_W-1:0] lim,
			input logic [DELAY_W-1:0] dly, input logic [FINE_W-1:0] fine);
		if (!(sent >= 500 && sent < 800)) begin
			while ($urandom_range(99) < 8) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		seconds_limit <= lim;
		delay_ticks   <= dly;
		fine_count    <= fine;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// A tick with random content in the fields that a tick ignores.
	task automatic offer_tick();
		offer(CMD_TICK, LIMIT_W'($urandom()), DELAY_W'($urandom()), FINE_W'($urandom()));
	endtask

	task automatic offer_read();
		offer(CMD_READ, LIMIT_W'($urandom()), DELAY_W'($urandom()), FINE_W'($urandom()));
	endtask

	// A well formed timing run: a start, then enough ticks to pass the delay and reach the
	// limit, with reads sprinkled in. Most limits are short so that runs really complete;
	// a few use any limit or a long delay and are simply cut off.
	task automatic clean_run();
		logic [LIMIT_W-1:0] lim;
		logic [DELAY_W-1:0] dly;
		int                 len;
		int                 secs;
		int                 r;
		r = $urandom_range(99);
		lim = (r < 75) ? LIMIT_W'($urandom_range(1, 2)) : LIMIT_W'($urandom());
		r = $urandom_range(99);
		if (r < 80)
			dly = DELAY_W'($urandom_range(0, 12));
		else if (r < 95)
			dly = DELAY_W'($urandom_range(0, 300));
		else
			dly = DELAY_W'($urandom());
		offer(CMD_START, lim, dly, FINE_W'($urandom()));
		// A zero limit only completes after the seconds count wraps.
		secs = (lim == '0) ? 128 : int'(lim);
		len = int'(dly) + secs * TPS + $urandom_range(2, 20);
		if (len > 450)
			len = 450;
		for (int k = 0; k < len && sent < TOTAL_ITEMS; k++) begin
			if ($urandom_range(99) < 88)
				offer_tick();
			else
				offer_read();
		end
	endtask

	// A broken run: stops and restarts at random points, plus commands that are pure noise.
	task automatic broken_run();
		int len;
		int r;
		offer(CMD_START, LIMIT_W'($urandom_range(1, 3)), DELAY_W'($urandom_range(0, 20)),
			FINE_W'($urandom()));
		len = $urandom_range(20, 200);
		for (int k = 0; k < len && sent < TOTAL_ITEMS; k++) begin
			r = $urandom_range(99);
			if (r < 70)
				offer_tick();
			else if (r < 82)
				offer_read();
			else if (r < 86)
				offer(CMD_STOP, LIMIT_W'($urandom()), DELAY_W'($urandom()), FINE_W'($urandom()));
			else if (r < 90)
				offer(CMD_START, LIMIT_W'($urandom_range(1, 2)), DELAY_W'($urandom_range(0, 8)),
					FINE_W'($urandom()));
			else
				offer(CMD_W'($urandom()), LIMIT_W'($urandom()), DELAY_W'($urandom()),
					FINE_W'($urandom()));
		end
	endtask

	// Receiver: stalls at random with a chance of about 8 in a hundred, holds off for a long
	// stretch once early on so the block fills up and stalls its input, and then leaves a
	// long stretch with no stall at all.
	initial begin
		int cyc;
		int hold;
		cyc  = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 300)
				hold = 80;
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else if (cyc >= 1200 && cyc < 1600) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 8);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Commands on an idle timer, with all-ones and all-zeros fields.
		offer(CMD_READ, '0, '0, 16'hFFFF);
		offer(CMD_TICK, 7'h7F, 15'h7FFF, 16'hFFFF);
		offer(CMD_STOP, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		// Largest limit and delay; a read during the delay finds the timer not running,
		// and a stop ends the delay on the next tick.
		offer(CMD_START, 7'd127, 15'h7FFF, '0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_READ, '0, '0, 16'hFFFF);
		offer(CMD_STOP, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		// A zero delay behaves as one tick, so the first tick starts the timer.
		offer(CMD_START, 7'd1, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_READ, '0, '0, 16'hFFFF);
		offer(CMD_READ, 7'h7F, 15'h7FFF, '0);
		// Restart while running, with a zero limit; the timer is idle until the next tick.
		offer(CMD_START, '0, 15'd1, 16'hFFFF);
		offer(CMD_READ, '0, '0, 16'hFFFF);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_READ, '0, '0, 16'h1234);
		// Start and stop with no tick between them: the stop wins on the next tick.
		offer(CMD_START, 7'd127, 15'd1, '0);
		offer(CMD_STOP, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_READ, '0, '0, 16'hFFFF);

		// Random part: mostly well formed timing runs, some broken ones.
		while (sent < TOTAL_ITEMS) begin
			if ($urandom_range(99) < 75)
				clean_run();
			else
				broken_run();
		end
		in_valid <= 1'b0;

		// Drain: wait until every report has been seen, then a few more cycles so that a
		// stray report would still show up.
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
